/* rtl/btpc_pkg.sv */
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int unsigned NumRegs   = 7;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DivSteps  = 32;

  typedef enum logic [2:0] {
    RegT1   = 3'd0,
    RegT2T3 = 3'd1,
    RegP1   = 3'd2,
    RegP2P3 = 3'd3,
    RegP4P5 = 3'd4,
    RegP6P7 = 3'd5,
    RegP8P9 = 3'd6,
    RegNone = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  // Arithmetic shift right of a 32-bit word by a constant.
  function automatic logic [31:0] asr32(input logic [31:0] a, input int unsigned n);
    asr32 = 32'($signed(a) >>> n);
  endfunction

  // Signed division by 2^n, truncating toward zero.
  function automatic logic [31:0] sdivp2(input logic [31:0] a, input int unsigned n);
    logic [31:0] bias;
    bias = a[31] ? ((32'd1 << n) - 32'd1) : 32'd0;
    sdivp2 = 32'($signed(a + bias) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] h);
    sx16 = {{16{h[15]}}, h};
  endfunction

endpackage

/* rtl/btpc_regs.sv */
`timescale 1ns / 1ps
module btpc_regs
  import btpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output calib_t               calib_o
);

  logic [15:0] t1_q, p1_q;
  logic [31:0] t23_q, p23_q, p45_q, p67_q, p89_q;
  reg_idx_e    idx;
  logic        wr_en;

  assign idx   = (paddr[1:0] == 2'b00) ? reg_idx_e'(paddr[4:2]) : RegNone;
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q  <= '0;
      p1_q  <= '0;
      t23_q <= '0;
      p23_q <= '0;
      p45_q <= '0;
      p67_q <= '0;
      p89_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegT1:   t1_q  <= pwdata[15:0];
        RegT2T3: t23_q <= pwdata;
        RegP1:   p1_q  <= pwdata[15:0];
        RegP2P3: p23_q <= pwdata;
        RegP4P5: p45_q <= pwdata;
        RegP6P7: p67_q <= pwdata;
        RegP8P9: p89_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegT1:   prdata = {16'd0, t1_q};
      RegT2T3: prdata = t23_q;
      RegP1:   prdata = {16'd0, p1_q};
      RegP2P3: prdata = p23_q;
      RegP4P5: prdata = p45_q;
      RegP6P7: prdata = p67_q;
      RegP8P9: prdata = p89_q;
      default: prdata = '0;
    endcase
  end

  assign calib_o = '{t1: t1_q, t2: t23_q[15:0], t3: t23_q[31:16], p1: p1_q,
                     p2: p23_q[15:0], p3: p23_q[31:16], p4: p45_q[15:0],
                     p5: p45_q[31:16], p6: p67_q[15:0], p7: p67_q[31:16],
                     p8: p89_q[15:0], p9: p89_q[31:16]};

endmodule

/* rtl/btpc_divider.sv */
`timescale 1ns / 1ps
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// A side word rides along with each transaction.
module btpc_divider
  import btpc_pkg::*;
#(
  parameter int unsigned SideWidth = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          dividend_i,
  input  logic [31:0]          divisor_i,
  input  logic [SideWidth-1:0] side_i,
  output logic                 valid_o,
  output logic [31:0]          quotient_o,
  output logic [SideWidth-1:0] side_o
);

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic                 vld_in, vld_q;
    logic [31:0]          rem_in, quo_in, den_in;
    logic [31:0]          rem_q, quo_q, den_q;
    logic [SideWidth-1:0] side_in, side_q;
    logic [32:0]          trial;
    logic [32:0]          shifted;

    if (s == 0) begin : g_src
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign quo_in  = dividend_i;
      assign den_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_src
      assign vld_in  = g_step[s-1].vld_q;
      assign rem_in  = g_step[s-1].rem_q;
      assign quo_in  = g_step[s-1].quo_q;
      assign den_in  = g_step[s-1].den_q;
      assign side_in = g_step[s-1].side_q;
    end

    assign shifted = {rem_in, quo_in[31]};
    assign trial   = shifted - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
      end else begin
        rem_q <= shifted[31:0];
      end
      quo_q  <= {quo_in[30:0], ~trial[32]};
      den_q  <= den_in;
      side_q <= side_in;
    end
  end

  assign valid_o    = g_step[DivSteps-1].vld_q;
  assign quotient_o = g_step[DivSteps-1].quo_q;
  assign side_o     = g_step[DivSteps-1].side_q;

endmodule

/* rtl/btpc_front.sv */
`timescale 1ns / 1ps
// Temperature compensation and pressure divisor preparation, six stages.
module btpc_front
  import btpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  calib_t      calib_i,
  input  logic        valid_i,
  input  logic [19:0] rp_i,
  input  logic [19:0] rt_i,
  output logic        valid_o,
  output logic [31:0] temp_o,
  output logic [31:0] tfine_o,
  output logic [31:0] var1_o,
  output logic [31:0] num_o
);

  localparam int unsigned Stages = 6;
  logic [Stages:1] vld_q;

  // Stage 1: products for temperature.
  logic [31:0] s1_a_q, s1_dd_q;
  logic [19:0] s1_rp_q;
  // Stage 2
  logic [31:0] s2_a_q, s2_m_q;
  logic [19:0] s2_rp_q;
  // Stage 3: tfine
  logic [31:0] s3_tf_q;
  logic [19:0] s3_rp_q;
  // Stage 4
  logic [31:0] s4_tf_q, s4_temp_q, s4_a_q, s4_q_q, s4_a5_q, s4_p2a_q;
  logic [19:0] s4_rp_q;
  // Stage 5
  logic [31:0] s5_tf_q, s5_temp_q, s5_b_q, s5_p3q_q, s5_p2a_q;
  logic [19:0] s5_rp_q;
  // Stage 6
  logic [31:0] s6_tf_q, s6_temp_q, s6_b_q, s6_a_q;
  logic [19:0] s6_rp_q;

  logic [31:0] t1x, d1, dd, a4, b6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-1:1], valid_i};
    end
  end

  assign t1x = {16'd0, calib_i.t1};
  assign d1  = {15'd0, rt_i[19:3]} - {t1x[30:0], 1'b0};
  assign dd  = {16'd0, rt_i[19:4]} - t1x;

  assign a4 = sdivp2(s3_tf_q, 1) - 32'd64000;
  assign b6 = s5_b_q;

  always_ff @(posedge clk_i) begin
    s1_a_q  <= 32'(d1 * sx16(calib_i.t2));
    s1_dd_q <= 32'(dd * dd);
    s1_rp_q <= rp_i;

    s2_a_q  <= asr32(s1_a_q, 11);
    s2_m_q  <= 32'(asr32(s1_dd_q, 12) * sx16(calib_i.t3));
    s2_rp_q <= s1_rp_q;

    s3_tf_q <= s2_a_q + asr32(s2_m_q, 14);
    s3_rp_q <= s2_rp_q;

    s4_tf_q   <= s3_tf_q;
    s4_temp_q <= asr32(32'(s3_tf_q * 32'd5) + 32'd128, 8);
    s4_a_q    <= a4;
    s4_q_q    <= 32'(sdivp2(a4, 2) * sdivp2(a4, 2));
    s4_a5_q   <= 32'(a4 * sx16(calib_i.p5));
    s4_p2a_q  <= 32'(sx16(calib_i.p2) * a4);
    s4_rp_q   <= s3_rp_q;

    s5_tf_q   <= s4_tf_q;
    s5_temp_q <= s4_temp_q;
    s5_b_q    <= sdivp2(32'(sdivp2(s4_q_q, 11) * sx16(calib_i.p6)) +
                        {s4_a5_q[30:0], 1'b0}, 2) + {calib_i.p4, 16'd0};
    s5_p3q_q  <= 32'(sx16(calib_i.p3) * sdivp2(s4_q_q, 13));
    s5_p2a_q  <= sdivp2(s4_p2a_q, 1);
    s5_rp_q   <= s4_rp_q;

    s6_tf_q   <= s5_tf_q;
    s6_temp_q <= s5_temp_q;
    s6_b_q    <= b6;
    s6_a_q    <= 32'((32'd32768 + sdivp2(sdivp2(s5_p3q_q, 3) + s5_p2a_q, 18)) *
                     {16'd0, calib_i.p1});
    s6_rp_q   <= s5_rp_q;
  end

  assign valid_o = vld_q[Stages];
  assign temp_o  = s6_temp_q;
  assign tfine_o = s6_tf_q;
  assign var1_o  = sdivp2(s6_a_q, 15);
  assign num_o   = 32'(((32'd1048576 - {12'd0, s6_rp_q}) - sdivp2(s6_b_q, 12)) *
                       32'd3125);

endmodule

/* rtl/btpc_back.sv */
`timescale 1ns / 1ps
// Pressure division and final correction.
module btpc_back
  import btpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  calib_t      calib_i,
  input  logic        valid_i,
  input  logic [31:0] temp_i,
  input  logic [31:0] tfine_i,
  input  logic [31:0] var1_i,
  input  logic [31:0] num_i,
  output logic        valid_o,
  output logic [31:0] temp_o,
  output logic [31:0] tfine_o,
  output logic [31:0] press_o,
  output logic        dz_o
);

  localparam int unsigned SideW = 32 + 32 + 1 + 1;

  // Stage A: pick the dividend and remember the branch.
  logic        a_vld_q;
  logic [31:0] a_div_q, a_den_q, a_temp_q, a_tf_q;
  logic        a_big_q, a_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_big_q  <= num_i[31];
    a_div_q  <= num_i[31] ? num_i : {num_i[30:0], 1'b0};
    a_den_q  <= var1_i;
    a_dz_q   <= (var1_i == 32'd0);
    a_temp_q <= temp_i;
    a_tf_q   <= tfine_i;
  end

  logic              d_vld;
  logic [31:0]       d_quo;
  logic [SideW-1:0]  d_side;

  btpc_divider #(
    .SideWidth(SideW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .valid_i    (a_vld_q),
    .dividend_i (a_div_q),
    .divisor_i  (a_den_q),
    .side_i     ({a_temp_q, a_tf_q, a_big_q, a_dz_q}),
    .valid_o    (d_vld),
    .quotient_o (d_quo),
    .side_o     (d_side)
  );

  // Stage B: pressure estimate and its scaled products.
  logic        b_vld_q, b_dz_q;
  logic [31:0] b_p_q, b_q_q, b_pb_q, b_temp_q, b_tf_q;
  logic [31:0] p_est;

  assign p_est = d_side[1] ? {d_quo[30:0], 1'b0} : d_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    b_p_q    <= p_est;
    b_q_q    <= 32'({3'd0, p_est[31:3]} * {3'd0, p_est[31:3]});
    b_pb_q   <= 32'({2'd0, p_est[31:2]} * sx16(calib_i.p8));
    b_dz_q   <= d_side[0];
    b_temp_q <= d_side[SideW-1 -: 32];
    b_tf_q   <= d_side[SideW-33 -: 32];
  end

  // Stage C: second products.
  logic        c_vld_q, c_dz_q;
  logic [31:0] c_p_q, c_a_q, c_b_q, c_temp_q, c_tf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_p_q    <= b_p_q;
    c_a_q    <= 32'(sx16(calib_i.p9) * {13'd0, b_q_q[31:13]});
    c_b_q    <= sdivp2(b_pb_q, 13);
    c_dz_q   <= b_dz_q;
    c_temp_q <= b_temp_q;
    c_tf_q   <= b_tf_q;
  end

  // Stage D: final sum, registered onto the outputs.
  logic        o_vld_q, o_dz_q;
  logic [31:0] o_p_q, o_temp_q, o_tf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_p_q    <= c_dz_q ? 32'd0 :
                c_p_q + sdivp2(sdivp2(c_a_q, 12) + c_b_q + sx16(calib_i.p7), 4);
    o_dz_q   <= c_dz_q;
    o_temp_q <= c_temp_q;
    o_tf_q   <= c_tf_q;
  end

  assign valid_o = o_vld_q;
  assign temp_o  = o_temp_q;
  assign tfine_o = o_tf_q;
  assign press_o = o_p_q;
  assign dz_o    = o_dz_q;

endmodule

/* rtl/baro_temp_pressure_compensation.sv */
`timescale 1ns / 1ps
// Temperature and pressure compensation for a barometric sensor.
// Load the seven calibration registers through the APB port (byte address
// 4*i, pready always high, reads return the stored value), then pulse
// start_i with a raw pressure and temperature pair. busy_o is always low,
// so a new pair is taken in every cycle.
// Each accepted transaction leaves the block with done_o high for one
// cycle alongside the temperature, fine temperature, pressure and
// divide-by-zero flag. It passes through the 32-stage restoring divider
// that forms the pressure quotient, one bit per stage, plus six stages
// of temperature and divisor math and four of correction.
// Results come out in the order the pairs went in; the receiver must take
// each one in the cycle it appears.
// Reset clears all calibration registers to zero and empties the pipeline;
// no result is produced for anything accepted before reset.
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [19:0]          raw_pressure_i,
  input  logic [19:0]          raw_temperature_i,
  output logic                 done_o,
  output logic signed [31:0]   temperature_centideg_o,
  output logic signed [31:0]   fine_temperature_o,
  output logic [31:0]          pressure_pa_o,
  output logic                 divide_zero_o
);

  calib_t      calib;
  logic        f_vld;
  logic [31:0] f_temp, f_tf, f_v1, f_num;
  logic [31:0] b_temp, b_tf;

  assign busy_o = 1'b0;

  btpc_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .calib_o (calib)
  );

  btpc_front u_front (
    .clk_i,
    .rst_ni,
    .calib_i (calib),
    .valid_i (start_i),
    .rp_i    (raw_pressure_i),
    .rt_i    (raw_temperature_i),
    .valid_o (f_vld),
    .temp_o  (f_temp),
    .tfine_o (f_tf),
    .var1_o  (f_v1),
    .num_o   (f_num)
  );

  btpc_back u_back (
    .clk_i,
    .rst_ni,
    .calib_i (calib),
    .valid_i (f_vld),
    .temp_i  (f_temp),
    .tfine_i (f_tf),
    .var1_i  (f_v1),
    .num_i   (f_num),
    .valid_o (done_o),
    .temp_o  (b_temp),
    .tfine_o (b_tf),
    .press_o (pressure_pa_o),
    .dz_o    (divide_zero_o)
  );

  assign temperature_centideg_o = $signed(b_temp);
  assign fine_temperature_o     = $signed(b_tf);

endmodule

/* bench/baro_temp_pressure_compensation_tb.sv */
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_tb;
  import btpc_pkg::*;

  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               dz;
  } reading_t;

  typedef struct {
    logic [19:0] rp;
    logic [19:0] rt;
    bit          typed;
    reading_t    value;
  } vector_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [19:0]          raw_pressure_i = '0;
  logic [19:0]          raw_temperature_i = '0;
  logic                 done_o;
  logic signed [31:0]   temperature_centideg_o;
  logic signed [31:0]   fine_temperature_o;
  logic [31:0]          pressure_pa_o;
  logic                 divide_zero_o;

  logic [31:0] calib_copy [NumRegs];
  reading_t    pending_readings [$];
  reading_t    typed_readings [$];
  bit          use_typed [$];
  int          mismatches = 0;
  int          readings_checked = 0;
  int          dz_seen = 0;
  int          phases_run = 0;
  bit          allow_idle = 1'b1;

  baro_temp_pressure_compensation uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] ext16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] shr_arith(input logic [31:0] a, input int n);
    logic signed [31:0] s;
    s = a;
    return s >>> n;
  endfunction

  function automatic logic [31:0] div_trunc(input logic [31:0] a, input longint d);
    longint s;
    s = $signed(a);
    return 32'(s / d);
  endfunction

  function automatic reading_t compensate(input logic [19:0] rp_in, input logic [19:0] rt_in);
    logic [31:0] rp, rt, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, tfine, press, sc;
    reading_t r;
    rp = {12'd0, rp_in};
    rt = {12'd0, rt_in};
    t1 = {16'd0, calib_copy[RegT1][15:0]};
    t2 = ext16(calib_copy[RegT2T3][15:0]);
    t3 = ext16(calib_copy[RegT2T3][31:16]);
    p1 = {16'd0, calib_copy[RegP1][15:0]};
    p2 = ext16(calib_copy[RegP2P3][15:0]);
    p3 = ext16(calib_copy[RegP2P3][31:16]);
    p4 = ext16(calib_copy[RegP4P5][15:0]);
    p5 = ext16(calib_copy[RegP4P5][31:16]);
    p6 = ext16(calib_copy[RegP6P7][15:0]);
    p7 = ext16(calib_copy[RegP6P7][31:16]);
    p8 = ext16(calib_copy[RegP8P9][15:0]);
    p9 = ext16(calib_copy[RegP8P9][31:16]);

    sc = (rt >> 3) - (t1 << 1);
    sc = sc * t2;
    a = shr_arith(sc, 11);
    d = (rt >> 4) - t1;
    sc = d * d;
    sc = shr_arith(sc, 12) * t3;
    b = shr_arith(sc, 14);
    tfine = a + b;
    sc = tfine * 32'd5 + 32'd128;
    r.temp = shr_arith(sc, 8);
    r.fine = tfine;

    a = div_trunc(tfine, 2) - 32'd64000;
    q = div_trunc(a, 4) * div_trunc(a, 4);
    b = div_trunc(q, 2048) * p6;
    sc = a * p5;
    b = b + sc * 32'd2;
    b = div_trunc(b, 4) + p4 * 32'd65536;
    sc = p3 * div_trunc(q, 8192);
    d = p2 * a;
    a = div_trunc(div_trunc(sc, 8) + div_trunc(d, 2), 262144);
    sc = (32'd32768 + a) * p1;
    a = div_trunc(sc, 32768);

    press = '0;
    r.dz = (a == 32'd0);
    if (!r.dz) begin
      press = ((32'd1048576 - rp) - div_trunc(b, 4096)) * 32'd3125;
      // Large values are divided before doubling to keep the quotient in range.
      if (press < 32'h8000_0000) press = (press * 32'd2) / a;
      else press = (press / a) * 32'd2;
      q = ((press / 32'd8) * (press / 32'd8)) / 32'd8192;
      sc = p9 * q;
      a = div_trunc(sc, 4096);
      sc = (press / 32'd4) * p8;
      b = div_trunc(sc, 8192);
      press = press + div_trunc(a + b + p7, 16);
    end
    r.press = press;
    return r;
  endfunction

  // Acceptance and result checking both happen on the rising edge.
  always @(posedge clk_i) begin
    reading_t want, got;
    if (rst_ni && start_i && !busy_o) begin
      if (use_typed.size() != 0 && use_typed.pop_front())
        pending_readings.push_back(typed_readings.pop_front());
      else
        pending_readings.push_back(compensate(raw_pressure_i, raw_temperature_i));
    end
    if (rst_ni && done_o) begin
      got = '{temperature_centideg_o, fine_temperature_o, pressure_pa_o, divide_zero_o};
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (got.dz) dz_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic write_calib(input int idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(idx * 4);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // Index RegNone is ignored by the block; larger indexes wrap in the five-bit address.
    if (idx < NumRegs) calib_copy[idx] = (idx == RegT1 || idx == RegP1) ? val & 32'hFFFF : val;
  endtask

  task automatic load_calib(input int kind);
    logic [31:0] v [NumRegs];
    v = '{32'd27504, {16'hFC18, 16'd26435}, 32'd36477, {16'd3024, 16'hD643},
          {16'd140, 16'd2855}, {16'd15500, 16'hFFF9}, {16'd6000, 16'hC6F8}};
    for (int i = 0; i < NumRegs; i++) begin
      case (kind)
        1, 6: v[i] = $urandom;
        2: v[i] = 32'hFFFF_FFFF;
        3: v[i] = 32'h7FFF_7FFF;
        4: v[i] = 32'h8000_8000;
        5: v[i] = v[i] ^ ($urandom & 32'h00FF_00FF);
        default: ;
      endcase
    end
    if (kind == 6) v[RegP1] = '0;
    for (int i = 0; i < NumRegs; i++) write_calib(i, v[i]);
    write_calib(RegNone, $urandom);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_pair(input logic [19:0] rp, input logic [19:0] rt);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    raw_pressure_i <= rp;
    raw_temperature_i <= rt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    @(negedge clk_i);
    start_i <= 1'b0;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [19:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2: return 20'h7FFFF + 20'($urandom_range(0, 3));
      default: return 20'($urandom);
    endcase
  endfunction

  vector_t reset_vectors [] = '{
    '{20'h00000, 20'h00000, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b1}},
    '{20'hFFFFF, 20'hFFFFF, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b1}},
    '{20'hFFFFF, 20'h00000, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b1}},
    '{20'h00000, 20'hFFFFF, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b1}},
    '{20'h80000, 20'h7FFFF, 1'b1, '{32'sd0, 32'sd0, 32'd0, 1'b1}}
  };

  vector_t typical_vectors [] = '{
    '{20'd415148, 20'd519888, 1'b0, '0},
    '{20'h00000, 20'h00000, 1'b0, '0},
    '{20'hFFFFF, 20'hFFFFF, 1'b0, '0},
    '{20'h00001, 20'h00001, 1'b0, '0},
    '{20'hAAAAA, 20'h55555, 1'b0, '0},
    '{20'h55555, 20'hAAAAA, 1'b0, '0},
    '{20'hFFFFF, 20'h00000, 1'b0, '0},
    '{20'h00000, 20'hFFFFF, 1'b0, '0},
    '{20'h80000, 20'h80000, 1'b0, '0},
    '{20'd300000, 20'd420000, 1'b0, '0}
  };

  initial begin
    for (int i = 0; i < NumRegs; i++) calib_copy[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (reset_vectors[i]) begin
      use_typed.push_back(1'b1);
      typed_readings.push_back(reset_vectors[i].value);
      send_pair(reset_vectors[i].rp, reset_vectors[i].rt);
    end
    drain();

    for (int k = 0; k < 7; k += (k == 0) ? 2 : 4) begin
      load_calib(k);
      foreach (typical_vectors[i]) send_pair(typical_vectors[i].rp, typical_vectors[i].rt);
      drain();
    end

    for (int ph = 0; ph < 9; ph++) begin
      load_calib(ph % 7);
      phases_run++;
      allow_idle = (ph < 8);
      for (int n = 0; n < 150; n++) send_pair(pick_raw(), pick_raw());
      drain();
    end

    if (pending_readings.size() != 0) mismatches++;
    $display("Checked %0d results over %0d random calibration phases, %0d with zero divisor.",
             readings_checked, phases_run, dz_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* baro_temp_pressure_compensation.f */
rtl/btpc_pkg.sv
rtl/btpc_regs.sv
rtl/btpc_divider.sv
rtl/btpc_front.sv
rtl/btpc_back.sv
rtl/baro_temp_pressure_compensation.sv
bench/baro_temp_pressure_compensation_tb.sv
